[rtl/core/assert_macros.svh]
// assertion helpers, clocked on clk and disabled while rst is high
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);
`define ASSERT_IMPLY_NEXT(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);
`else
`define ASSERT_IMPLY(lbl, a, b, msg)
`define ASSERT_IMPLY_NEXT(lbl, a, b, msg)
`endif
`endif

[rtl/core/pwlf_pkg.sv]
`default_nettype none
package pwlf_pkg;
  localparam int POS_W  = 32;
  localparam int MAG_W  = 33;
  localparam int SQ_W   = 66;
  localparam int NUM_W  = 99;
  localparam int DEN_W  = 70;
  localparam int F_W    = 50;
  localparam int K_W    = 31;
  localparam int HOP_W  = 16;
  localparam int KK_W   = 62;
  localparam int LEN_W  = 47;
  localparam int ROOT_W = 34;
  localparam int ACC_W  = 48;

  localparam logic [1:0] KIND_SPRING = 2'd0;
  localparam logic [1:0] KIND_ATTR   = 2'd1;
  localparam logic [1:0] KIND_REP    = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQ, ST_DEC, ST_ROOT, ST_NUMGO, ST_NUM, ST_DIVGO, ST_DIV, ST_ACC, ST_DONE
  } state_t;

  typedef struct packed {
    logic start_sq;
    logic start_num;
    logic start_div;
  } lane_ctl_t;
endpackage
`default_nettype wire

[rtl/core/pwlf_smul.sv]
`default_nettype none
module pwlf_smul #(
  parameter int A_W = 33,
  parameter int B_W = 66
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [A_W-1:0]   a,
  input  wire logic [B_W-1:0]   b,
  output logic                  busy,
  output logic [A_W+B_W-1:0]    p
);
  localparam int P_W   = A_W + B_W;
  localparam int CNT_W = $clog2(B_W + 1);

  logic [P_W-1:0]   acc;
  logic [P_W-1:0]   a_sh;
  logic [B_W-1:0]   b_sh;
  logic [CNT_W-1:0] cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(B_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) busy <= 1'b0;
    end
  end

  // shift-add, one multiplier bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      acc  <= '0;
      a_sh <= P_W'(a);
      b_sh <= b;
    end else if (busy) begin
      if (b_sh[0]) acc <= acc + a_sh;
      a_sh <= a_sh << 1;
      b_sh <= b_sh >> 1;
    end
  end

  assign p = acc;
endmodule
`default_nettype wire

[rtl/core/pwlf_sqrt.sv]
`default_nettype none
module pwlf_sqrt (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic [pwlf_pkg::SQ_W-1:0]   s,
  output logic                      busy,
  output logic [pwlf_pkg::ROOT_W-1:0] root
);
  import pwlf_pkg::*;

  logic [2*ROOT_W-1:0] sh;
  logic [ROOT_W+3:0]   rem;
  logic [5:0]          cnt;
  logic [ROOT_W+3:0]   rem_t;
  logic [ROOT_W+3:0]   trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 6'(ROOT_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == 6'd1) busy <= 1'b0;
    end
  end

  // two radicand bits per step
  assign rem_t = {rem[ROOT_W+1:0], sh[2*ROOT_W-1 -: 2]};
  assign trial = {2'b00, root, 2'b01};

  always_ff @(posedge clk) begin
    if (start) begin
      sh   <= (2*ROOT_W)'(s);
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      sh <= sh << 2;
      if (rem_t >= trial) begin
        rem  <= rem_t - trial;
        root <= {root[ROOT_W-2:0], 1'b1};
      end else begin
        rem  <= rem_t;
        root <= {root[ROOT_W-2:0], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

[rtl/core/pwlf_div.sv]
`default_nettype none
module pwlf_div (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [pwlf_pkg::NUM_W-1:0] num,
  input  wire logic [pwlf_pkg::DEN_W-1:0] den,
  output logic                            busy,
  output logic [pwlf_pkg::F_W-1:0]        f
);
  import pwlf_pkg::*;

  localparam logic [NUM_W:0] F_CAP = (NUM_W+1)'(1) << (F_W - 1);

  logic [NUM_W-1:0] n_sh;
  logic [NUM_W-1:0] q;
  logic [DEN_W:0]   rem;
  logic [DEN_W-1:0] d;
  logic [6:0]       cnt;
  logic [DEN_W:0]   rem_t;
  logic             rnd;
  logic [NUM_W:0]   q_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 7'(NUM_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == 7'd1) busy <= 1'b0;
    end
  end

  assign rem_t = {rem[DEN_W-1:0], n_sh[NUM_W-1]};

  // restoring division, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      n_sh <= num;
      d    <= den;
      q    <= '0;
      rem  <= '0;
    end else if (busy) begin
      n_sh <= n_sh << 1;
      if (rem_t >= {1'b0, d}) begin
        rem <= rem_t - {1'b0, d};
        q   <= {q[NUM_W-2:0], 1'b1};
      end else begin
        rem <= rem_t;
        q   <= {q[NUM_W-2:0], 1'b0};
      end
    end
  end

  // round half away from zero, then cap the magnitude
  assign rnd = ({rem, 1'b0} >= {2'b00, d});
  assign q_r = {1'b0, q} + (NUM_W+1)'(rnd);
  assign f   = (q_r > F_CAP) ? F_CAP[F_W-1:0] : q_r[F_W-1:0];
endmodule
`default_nettype wire

[rtl/core/pwlf_lane.sv]
`default_nettype none
module pwlf_lane (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire pwlf_pkg::lane_ctl_t        ctl,
  input  wire logic [pwlf_pkg::MAG_W-1:0] mag,
  input  wire logic [pwlf_pkg::SQ_W-1:0]  oper,
  input  wire logic [pwlf_pkg::DEN_W-1:0] den,
  output logic                            busy,
  output logic [pwlf_pkg::SQ_W-1:0]       sq,
  output logic [pwlf_pkg::F_W-1:0]        f
);
  import pwlf_pkg::*;

  logic [SQ_W-1:0]  b_sel;
  logic [NUM_W-1:0] prod;
  logic             mul_busy;
  logic             div_busy;
  logic [MAG_W-1:0] mag_q;

  always_ff @(posedge clk) begin
    if (ctl.start_sq) mag_q <= mag;
  end

  // first pass squares the component, second forms the numerator
  assign b_sel = ctl.start_sq ? SQ_W'(mag) : oper;

  pwlf_smul #(.A_W(MAG_W), .B_W(SQ_W)) u_mul (
    .clk(clk), .rst(rst), .start(ctl.start_sq | ctl.start_num),
    .a(ctl.start_sq ? mag : mag_q), .b(b_sel), .busy(mul_busy), .p(prod)
  );

  pwlf_div u_div (
    .clk(clk), .rst(rst), .start(ctl.start_div), .num(prod), .den(den),
    .busy(div_busy), .f(f)
  );

  assign sq   = prod[SQ_W-1:0];
  assign busy = mul_busy | div_busy;
endmodule
`default_nettype wire

[rtl/core/pairwise_layout_force_top.sv]
// channel | transaction                                   | handshake
// s_      | vertex pair: tdata positions, hops, clear;     | s_tvalid / s_tready
//         | tuser force kind                               |
// m_      | tdata accumulator x,y,z; tuser skipped, sat    | m_tvalid / m_tready
// cfg_    | edge length k (31 bits)                        | cfg_valid / cfg_ready
// one pair at a time: squaring, then a square root for the spring, then the
// numerator pass, the divider and the merge for spring, attraction and
// repulsion; skipped and unused kinds go from squaring straight to the result.
// A new pair is accepted only once the block is back in idle.
// rst is synchronous: accumulator zero, k = 1.0, no result pending.
// a finished result waits in the output register while the next pair is taken;
// a pair that finishes while that result is still pending stalls until it leaves.
`default_nettype none
module pairwise_layout_force_top #(
  parameter int DIMS = 3
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // v_x, v_y, v_z, u_x, u_y, u_z, hop_count, clear_acc, zero fill
  input  wire logic [215:0] s_tdata,
  // req_type
  input  wire logic [1:0]   s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // acc_x, acc_y, acc_z
  output logic [143:0]      m_tdata,
  // skipped, saturated
  output logic [1:0]        m_tuser,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [30:0]  cfg_data
);
  import pwlf_pkg::*;

  state_t state, state_next;

  logic [K_W-1:0]   k;
  logic [1:0]       kind;
  logic [2:0]       neg;
  logic [MAG_W-1:0] mag [3];
  logic [SQ_W-1:0]  sq [3];
  logic [F_W-1:0]   f [3];
  logic [2:0]       lane_busy;
  logic signed [ACC_W-1:0] acc [3];
  logic [SQ_W-1:0]  s_sum;
  logic [SQ_W-1:0]  oper;
  logic [DEN_W-1:0] den;
  logic             diff_neg;
  logic             skip;
  logic             sat;
  logic             accept;
  lane_ctl_t        ctl;
  logic             start_root;
  logic             root_busy;
  logic [ROOT_W-1:0] root;
  logic             kk_busy, len_busy;
  logic [KK_W-1:0]  kk_p;
  logic [KK_W-1:0]  len_p;
  logic [LEN_W-1:0] len;
  logic signed [LEN_W:0] diff;
  logic             out_load;

  assign accept    = s_tvalid && s_tready;
  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = (state == ST_IDLE);
  assign len       = len_p[LEN_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) k <= K_W'(65536);
    else if (cfg_valid && cfg_ready) k <= cfg_data;
  end

  for (genvar i = 0; i < 3; i++) begin : g_lane
    logic signed [POS_W:0] d;
    assign d = $signed({s_tdata[96+32*i+31], s_tdata[96+32*i +: 32]})
             - $signed({s_tdata[32*i+31], s_tdata[32*i +: 32]});
    assign mag[i] = d[POS_W] ? MAG_W'(-d) : MAG_W'(d);
    if (i < DIMS) begin : g_on
      pwlf_lane u_lane (
        .clk(clk), .rst(rst), .ctl(ctl), .mag(mag[i]), .oper(oper), .den(den),
        .busy(lane_busy[i]), .sq(sq[i]), .f(f[i])
      );
    end else begin : g_off
      assign lane_busy[i] = 1'b0;
      assign sq[i]        = '0;
      assign f[i]         = '0;
    end
  end

  pwlf_smul #(.A_W(K_W), .B_W(K_W)) u_kk (
    .clk(clk), .rst(rst), .start(accept), .a(k), .b(k), .busy(kk_busy), .p(kk_p)
  );
  pwlf_smul #(.A_W(K_W), .B_W(K_W)) u_len (
    .clk(clk), .rst(rst), .start(accept), .a(k), .b(K_W'(s_tdata[207:192])),
    .busy(len_busy), .p(len_p)
  );
  pwlf_sqrt u_root (
    .clk(clk), .rst(rst), .start(start_root), .s(s_sum), .busy(root_busy), .root(root)
  );

  assign diff = $signed({(LEN_W-ROOT_W+1)'(0), root}) - $signed({1'b0, len});

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next    = state;
    ctl.start_sq  = accept;
    ctl.start_num = 1'b0;
    ctl.start_div = 1'b0;
    start_root    = 1'b0;
    out_load      = 1'b0;
    case (state)
      ST_IDLE: if (accept) state_next = ST_SQ;
      ST_SQ: if (!(|lane_busy) && !kk_busy && !len_busy) state_next = ST_DEC;
      ST_DEC: begin
        if (kind == KIND_SPRING && len != '0) begin
          start_root = 1'b1;
          state_next = ST_ROOT;
        end else if ((kind == KIND_ATTR && s_sum != '0 && kk_p != '0) ||
                     (kind == KIND_REP && s_sum != '0)) begin
          state_next = ST_NUMGO;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_ROOT: if (!root_busy) state_next = ST_NUMGO;
      ST_NUMGO: begin
        ctl.start_num = 1'b1;
        state_next    = ST_NUM;
      end
      ST_NUM: if (!(|lane_busy)) state_next = ST_DIVGO;
      ST_DIVGO: begin
        ctl.start_div = 1'b1;
        state_next    = ST_DIV;
      end
      ST_DIV: if (!(|lane_busy)) state_next = ST_ACC;
      ST_ACC: state_next = ST_DONE;
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // pair kind and signs, sum of squares, then operands for the numerator pass and divisor
  always_ff @(posedge clk) begin
    if (accept) begin
      kind <= s_tuser;
      for (int i = 0; i < 3; i++) neg[i] <= mag[i] != '0 &&
        ($signed(s_tdata[96+32*i +: 32]) < $signed(s_tdata[32*i +: 32]));
    end
    if (state == ST_SQ) s_sum <= sq[0] + sq[1] + sq[2];
    if (state == ST_DEC) begin
      case (kind)
        KIND_ATTR: begin
          oper <= s_sum;
          den  <= DEN_W'(kk_p);
        end
        default: begin
          oper <= SQ_W'(kk_p);
          den  <= (DEN_W'(s_sum) << 4) + (DEN_W'(s_sum) << 2);
        end
      endcase
    end
    if (state == ST_ROOT && !root_busy) begin
      diff_neg <= diff[LEN_W];
      oper     <= diff[LEN_W] ? SQ_W'(-diff) : SQ_W'(diff);
      den      <= DEN_W'(len);
    end
  end

  // merge: clear_acc zeroes on accept, skip flag, signed add of each lane result with clipping
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) acc[i] <= '0;
      skip <= 1'b0;
      sat  <= 1'b0;
    end else if (accept) begin
      if (s_tdata[208]) for (int i = 0; i < 3; i++) acc[i] <= '0;
      skip <= 1'b0;
      sat  <= 1'b0;
    end else if (state == ST_DEC) begin
      skip <= (kind == KIND_SPRING && len == '0) ||
              (kind == KIND_ATTR && (s_sum == '0 || kk_p == '0)) ||
              (kind == KIND_REP && s_sum == '0);
    end else if (state == ST_ACC) begin
      for (int i = 0; i < 3; i++) begin
        logic flip;
        logic signed [F_W+1:0] v;
        logic signed [F_W+1:0] sum;
        flip = (kind == KIND_SPRING) ? diff_neg : (kind == KIND_REP);
        v    = (neg[i] ^ flip) ? -$signed({2'b00, f[i]}) : $signed({2'b00, f[i]});
        sum  = (F_W+2)'(acc[i]) + v;
        if (sum > (F_W+2)'(signed'({1'b0, {(ACC_W-1){1'b1}}}))) begin
          acc[i] <= {1'b0, {(ACC_W-1){1'b1}}};
          sat    <= 1'b1;
        end else if (sum < -(F_W+2)'(signed'({1'b0, {(ACC_W-1){1'b1}}})) - 1) begin
          acc[i] <= {1'b1, {(ACC_W-1){1'b0}}};
          sat    <= 1'b1;
        end else begin
          acc[i] <= sum[ACC_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (out_load) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {acc[2], acc[1], acc[0]};
      m_tuser <= {sat, skip};
    end
  end

`include "assert_macros.svh"
  `ASSERT_IMPLY_NEXT(a_accept_squares, accept, state == ST_SQ, "pair did not start squaring")
  `ASSERT_IMPLY_NEXT(a_acc_done, state == ST_ACC, state == ST_DONE, "merge not followed by output")
  `ASSERT_IMPLY(a_root_idle, state == ST_NUM, !root_busy, "root still busy in numerator pass")
  `ASSERT_IMPLY(a_load_free, out_load, !m_tvalid || m_tready, "result overwritten while pending")
endmodule
`default_nettype wire
